[rtl/apjb_pkg.sv]
// ----------------------------------------------------------------------------
// apjb_pkg
// Shared widths, operation codes, register indexes and helpers of the
// audio playout jitter buffer.
// ----------------------------------------------------------------------------
package apjb_pkg;

  // field widths
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned GAIN_W    = 11;
  localparam int unsigned CFG_W     = 14;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned QF_W      = 14;
  localparam int unsigned FUNC_W    = 2;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_PULL = 2'd1,
    FUNC_TAKE = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_ABOVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP       = 2'd2;

  // register reset values and gain ceiling (four in Q3.8)
  localparam logic [GAIN_W-1:0] GAIN_RST  = 11'd256;
  localparam logic [GAIN_W-1:0] GAIN_MAX  = 11'd1024;
  localparam logic [CFG_W-1:0]  TRIM_RST  = 14'd7680;
  localparam logic [CFG_W-1:0]  KEEP_RST  = 14'd1920;

  typedef logic signed [SMP_W-1:0] sample_t;
  typedef logic [SMP_W-1:0]        mag_t;

  // magnitude of a Q1.15 sample; full-scale negative gives 32768
  function automatic mag_t smp_mag(sample_t s);
    mag_t m;
    m = s[SMP_W-1] ? mag_t'(-s) : mag_t'(s);
    return m;
  endfunction

endpackage

[rtl/apjb_in_if.sv]
// ----------------------------------------------------------------------------
// apjb_in_if
// Request channel: operation code, one stereo frame and the batch marker.
// ----------------------------------------------------------------------------
interface apjb_in_if
  import apjb_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic signed [SMP_W-1:0] sample_a;
  logic signed [SMP_W-1:0] sample_b;
  logic                batch_end;

  modport source (output valid, func, sample_a, sample_b, batch_end, input ready);
  modport sink   (input valid, func, sample_a, sample_b, batch_end, output ready);
endinterface

[rtl/apjb_out_if.sv]
// ----------------------------------------------------------------------------
// apjb_out_if
// Result channel: played frame, status flags, fill level, peaks and counters.
// ----------------------------------------------------------------------------
interface apjb_out_if
  import apjb_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] out_a;
  logic signed [SMP_W-1:0] out_b;
  logic                    starved;
  logic                    push_dropped;
  logic                    trimmed_now;
  logic [QF_W-1:0]         queued_frames;
  logic [SMP_W-1:0]        input_peak;
  logic [SMP_W-1:0]        output_peak;
  logic [CNT_W-1:0]        underrun_count;
  logic [CNT_W-1:0]        trim_count;

  modport source (
    output valid, out_a, out_b, starved, push_dropped, trimmed_now, queued_frames,
           input_peak, output_peak, underrun_count, trim_count,
    input  ready
  );
  modport sink (
    input  valid, out_a, out_b, starved, push_dropped, trimmed_now, queued_frames,
           input_peak, output_peak, underrun_count, trim_count,
    output ready
  );
endinterface

[rtl/apjb_frame_ram.sv]
// ----------------------------------------------------------------------------
// apjb_frame_ram
// Ring store of frames: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module apjb_frame_ram #(
  parameter  int unsigned DEPTH  = 8192,
  parameter  int unsigned DATA_W = 32,
  localparam int unsigned AW     = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/apjb_gain.sv]
// ----------------------------------------------------------------------------
// apjb_gain
// Two-stage playback gain: Q1.15 x Q3.8 multiply, then round half up and
// saturate back to Q1.15. One lane per channel.
// ----------------------------------------------------------------------------
module apjb_gain
  import apjb_pkg::*;
#(
  parameter int unsigned CHANNELS = 2
) (
  input  logic              clk_i,
  input  logic              mul_en_i,
  input  logic              sat_en_i,
  input  logic [GAIN_W-1:0] gain_i,
  input  sample_t           smp_i [CHANNELS],
  output sample_t           res_o [CHANNELS]
);

  localparam int unsigned PROD_W  = SMP_W + GAIN_W + 1;
  localparam int unsigned FRAC_W  = 8;
  localparam logic signed [PROD_W-1:0] RND     = PROD_W'(2 ** (FRAC_W - 1));
  localparam logic signed [PROD_W-1:0] SAT_HI  = PROD_W'(2 ** (SMP_W - 1) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO  = -SAT_HI - PROD_W'(1);

  logic signed [PROD_W-1:0] gain_s;
  logic signed [PROD_W-1:0] prod_q [CHANNELS];
  sample_t                  res_q  [CHANNELS];

  assign gain_s = $signed(PROD_W'(gain_i));

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] quo;

    // stage 1: product
    always_ff @(posedge clk_i) begin
      if (mul_en_i) begin
        prod_q[c] <= PROD_W'(smp_i[c]) * gain_s;
      end
    end

    // stage 2: round half up (floor after bias), then clamp
    assign rnd = prod_q[c] + RND;
    assign quo = rnd >>> FRAC_W;

    always_ff @(posedge clk_i) begin
      if (sat_en_i) begin
        if (quo > SAT_HI) begin
          res_q[c] <= SAT_HI[SMP_W-1:0];
        end else if (quo < SAT_LO) begin
          res_q[c] <= SAT_LO[SMP_W-1:0];
        end else begin
          res_q[c] <= quo[SMP_W-1:0];
        end
      end
    end

    assign res_o[c] = res_q[c];
  end

endmodule

[rtl/audio_playout_jitter_buffer.sv]
// ----------------------------------------------------------------------------
// audio_playout_jitter_buffer
// Stereo playout FIFO with chunk-end trimming, playback gain and peak meters.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_i (push a frame, pull a frame, take peaks, or
// no-op); every request yields exactly one result on out_o. Gain, trim level
// and keep level are to be written on the cfg port only while the block is
// idle; the block itself does not enforce this. One request is worked at a
// time by a small sequencer around the frame RAM (one write port, one read
// port with registered read data) and a two-stage gain multiplier. After
// acceptance, take / no-op go to S_EMIT; a pull reads the RAM, then passes
// S_PULL (multiply, or starved straight to S_EMIT), S_GAIN (round and
// saturate) and S_PEAK (peak update); a push passes S_PUSH, S_TRIM and, when
// the chunk end drops frames, S_TRIM_PTR. The result is loaded into an
// output register from S_EMIT; if the sink stalls, the sequencer holds the
// finished item and accepts nothing new until the output register frees up.
// Reset empties the FIFO, clears peaks, counters and the starved-block mark,
// and loads gain 256, trim level 7680 and keep level 1920. The frame RAM
// itself is not cleared; only frames that were written are ever read.
// ----------------------------------------------------------------------------
module audio_playout_jitter_buffer
  import apjb_pkg::*;
#(
  parameter int unsigned FIFO_FRAMES = 8192,
  parameter int unsigned CHANNELS    = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  apjb_in_if.sink              in_i,
  apjb_out_if.source           out_o
);

  localparam int unsigned PW     = $clog2(FIFO_FRAMES);
  localparam int unsigned FW     = $clog2(FIFO_FRAMES + 1);
  localparam int unsigned CMPW   = (FW > CFG_W) ? FW : CFG_W;
  localparam int unsigned DATA_W = SMP_W * CHANNELS;
  localparam logic [FW:0]   DEPTH_X  = (FW + 1)'(FIFO_FRAMES);
  localparam logic [FW-1:0] FULL_CNT = FW'(FIFO_FRAMES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_TRIM,
    S_TRIM_PTR,
    S_PULL,
    S_GAIN,
    S_PEAK,
    S_EMIT
  } state_e;

  // ring pointer advance with wrap at the store depth
  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] base, logic [FW-1:0] step);
    logic [FW:0] sum;
    sum = (FW + 1)'(base) + (FW + 1)'(step);
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[PW-1:0];
  endfunction

  state_e              state_q;
  func_e               func_q;
  sample_t             sa_q, sb_q;
  logic                last_q;
  logic [PW-1:0]       rp_q;
  logic [FW-1:0]       fill_q;
  logic [FW-1:0]       excess_q;
  mag_t                in_peak_q, out_peak_q;
  logic [CNT_W-1:0]    under_q, trims_q;
  logic                blk_starved_q;
  logic                starved_q, dropped_q, trimmed_q;
  logic [GAIN_W-1:0]   gain_q;
  logic [CFG_W-1:0]    trim_above_q, keep_q;

  // output register
  logic                out_valid_q;
  sample_t             out_a_q, out_b_q;
  logic                out_starved_q, out_dropped_q, out_trimmed_q;
  logic [QF_W-1:0]     out_queued_q;
  mag_t                out_inpk_q, out_outpk_q;
  logic [CNT_W-1:0]    out_under_q, out_trims_q;

  logic                in_fire;
  logic                emit_go;
  logic                ram_we, ram_re;
  logic [PW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata;
  sample_t             gain_in  [CHANNELS];
  sample_t             gain_res [CHANNELS];
  sample_t             res_a, res_b;
  mag_t                push_mag_a, push_mag_b, push_mag;
  mag_t                play_mag_a, play_mag_b, play_mag;
  logic [CMPW-1:0]     fill_ext, trim_ext, keep_ext, excess_ext;
  logic [CMPW-1:0]     excess_d;

  // handshake
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign emit_go    = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  // frame store access; writes happen only while no read is outstanding
  assign ram_we    = (state_q == S_PUSH) && (fill_q != FULL_CNT);
  assign ram_waddr = wrap_add(rp_q, fill_q);
  assign ram_re    = in_fire && (func_e'(in_i.func) == FUNC_PULL);

  always_comb begin
    ram_wdata = '0;
    ram_wdata[SMP_W-1:0] = sa_q;
    if (CHANNELS > 1) begin
      ram_wdata[DATA_W-1 -: SMP_W] = sb_q;
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      gain_in[c] = ram_rdata[c*SMP_W +: SMP_W];
    end
  end

  apjb_frame_ram #(
    .DEPTH  (FIFO_FRAMES),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  apjb_gain #(
    .CHANNELS (CHANNELS)
  ) u_gain (
    .clk_i    (clk_i),
    .mul_en_i (state_q == S_PULL),
    .sat_en_i (state_q == S_GAIN),
    .gain_i   (gain_q),
    .smp_i    (gain_in),
    .res_o    (gain_res)
  );

  // peak magnitudes
  assign res_a      = gain_res[0];
  assign res_b      = (CHANNELS > 1) ? gain_res[CHANNELS-1] : '0;
  assign push_mag_a = smp_mag(sa_q);
  assign push_mag_b = smp_mag(sb_q);
  assign push_mag   = (push_mag_b > push_mag_a) ? push_mag_b : push_mag_a;
  assign play_mag_a = smp_mag(res_a);
  assign play_mag_b = smp_mag(res_b);
  assign play_mag   = (play_mag_b > play_mag_a) ? play_mag_b : play_mag_a;

  // trim compare at a common width
  assign fill_ext   = CMPW'(fill_q);
  assign trim_ext   = CMPW'(trim_above_q);
  assign keep_ext   = CMPW'(keep_q);
  assign excess_ext = CMPW'(excess_q);
  assign excess_d   = fill_ext - keep_ext;

  // sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      rp_q          <= '0;
      fill_q        <= '0;
      in_peak_q     <= '0;
      out_peak_q    <= '0;
      under_q       <= '0;
      trims_q       <= '0;
      blk_starved_q <= 1'b0;
      gain_q        <= GAIN_RST;
      trim_above_q  <= TRIM_RST;
      keep_q        <= KEEP_RST;
      out_valid_q   <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GAIN: begin
            gain_q <= (cfg_data_i[GAIN_W-1:0] > GAIN_MAX) ? GAIN_MAX
                                                           : cfg_data_i[GAIN_W-1:0];
          end
          CFG_TRIM_ABOVE: trim_above_q <= cfg_data_i;
          CFG_KEEP:       keep_q       <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready && !emit_go) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            func_q    <= func_e'(in_i.func);
            sa_q      <= in_i.sample_a;
            sb_q      <= (CHANNELS > 1) ? in_i.sample_b : '0;
            last_q    <= in_i.batch_end;
            starved_q <= 1'b0;
            dropped_q <= 1'b0;
            trimmed_q <= 1'b0;
            unique case (func_e'(in_i.func))
              FUNC_PUSH: state_q <= S_PUSH;
              FUNC_PULL: state_q <= S_PULL;
              default:   state_q <= S_EMIT;
            endcase
          end
        end

        // store the frame unless full; meter the input either way
        S_PUSH: begin
          if (push_mag > in_peak_q) begin
            in_peak_q <= push_mag;
          end
          if (fill_q == FULL_CNT) begin
            dropped_q <= 1'b1;
          end else begin
            fill_q <= fill_q + FW'(1);
          end
          state_q <= S_TRIM;
        end

        // chunk end above the trim level drops the oldest frames
        S_TRIM: begin
          state_q <= S_EMIT;
          if (last_q && (fill_ext > trim_ext)) begin
            trimmed_q <= 1'b1;
            trims_q   <= trims_q + CNT_W'(1);
            if (fill_ext > keep_ext) begin
              excess_q <= excess_d[FW-1:0];
              fill_q   <= keep_ext[FW-1:0];
              state_q  <= S_TRIM_PTR;
            end
          end
        end

        S_TRIM_PTR: begin
          rp_q    <= wrap_add(rp_q, excess_ext[FW-1:0]);
          state_q <= S_EMIT;
        end

        // read data is here; start the gain or mark the block starved
        S_PULL: begin
          if (fill_q == '0) begin
            starved_q <= 1'b1;
            state_q   <= S_EMIT;
            if (last_q) begin
              under_q       <= under_q + CNT_W'(1);
              blk_starved_q <= 1'b0;
            end else begin
              blk_starved_q <= 1'b1;
            end
          end else begin
            rp_q    <= wrap_add(rp_q, FW'(1));
            fill_q  <= fill_q - FW'(1);
            state_q <= S_GAIN;
            if (last_q) begin
              if (blk_starved_q) begin
                under_q <= under_q + CNT_W'(1);
              end
              blk_starved_q <= 1'b0;
            end
          end
        end

        S_GAIN: state_q <= S_PEAK;

        S_PEAK: begin
          if (play_mag > out_peak_q) begin
            out_peak_q <= play_mag;
          end
          state_q <= S_EMIT;
        end

        // load the result once the output register is free
        S_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (func_q == FUNC_TAKE) begin
              in_peak_q  <= '0;
              out_peak_q <= '0;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result payload, captured with the transfer into the output register
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_a_q       <= (func_q == FUNC_PULL && !starved_q) ? res_a : '0;
      out_b_q       <= (func_q == FUNC_PULL && !starved_q) ? res_b : '0;
      out_starved_q <= starved_q;
      out_dropped_q <= dropped_q;
      out_trimmed_q <= trimmed_q;
      out_queued_q  <= fill_ext[QF_W-1:0];
      out_inpk_q    <= in_peak_q;
      out_outpk_q   <= out_peak_q;
      out_under_q   <= under_q;
      out_trims_q   <= trims_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_a          = out_a_q;
  assign out_o.out_b          = out_b_q;
  assign out_o.starved        = out_starved_q;
  assign out_o.push_dropped   = out_dropped_q;
  assign out_o.trimmed_now    = out_trimmed_q;
  assign out_o.queued_frames  = out_queued_q;
  assign out_o.input_peak     = out_inpk_q;
  assign out_o.output_peak    = out_outpk_q;
  assign out_o.underrun_count = out_under_q;
  assign out_o.trim_count     = out_trims_q;

endmodule

[rtl/apjb_checker.sv]
// ----------------------------------------------------------------------------
// apjb_checker
// Port-level checks of the playout jitter buffer, bound to the top level.
// ----------------------------------------------------------------------------
module apjb_checker
  import apjb_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SMP_W-1:0] out_a,
  input logic [SMP_W-1:0] out_b,
  input logic             out_starved,
  input logic             out_dropped,
  input logic             out_trimmed
);

  // a result held back by the sink stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // one request at a time: no acceptance right after a transfer in
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in work");

  // a starved pull plays silence
  a_silence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_starved |-> (out_a == '0) && (out_b == '0))
    else $error("starved pull gave a non-silent frame");

  // starved only comes from a pull, push flags only from a push
  a_flag_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_starved |-> !out_dropped && !out_trimmed)
    else $error("pull and push flags set together");

endmodule

bind audio_playout_jitter_buffer apjb_checker u_apjb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_a       (out_o.out_a),
  .out_b       (out_o.out_b),
  .out_starved (out_o.starved),
  .out_dropped (out_o.push_dropped),
  .out_trimmed (out_o.trimmed_now)
);
